// ----- sv/e2q_pkg.sv -----
// Shared constants, types and CORDIC table for the Euler-to-quaternion core.
`default_nettype none
package e2q_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int ANGLE_BITS    = 16;
  localparam int TABLE_LEN     = 24;
  localparam int NUM_STAGES    = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
  localparam int STAGE_W       = $clog2(TABLE_LEN);
  localparam int XY_W          = 33;
  localparam int Z_W           = ANGLE_BITS + 3;
  localparam int SC            = ANGLE_BITS - 16;
  localparam logic signed [XY_W-1:0] CORDIC_GAIN = XY_W'(64'sd652032874);

  typedef logic signed [XY_W-1:0] xy_t;
  typedef logic signed [Z_W-1:0]  ang_t;

  // One angle lane inside a CORDIC cell.
  typedef struct packed {
    xy_t  x;
    xy_t  y;
    ang_t z;
  } lane_t;

  typedef struct packed {
    lane_t yaw;
    lane_t pitch;
    lane_t roll;
  } cell_t;

  function automatic logic [31:0] atan_raw(input int i);
    logic [31:0] r;
    r = 32'd0;
    case (i)
      0:  r = 32'd536870912;
      1:  r = 32'd316933406;
      2:  r = 32'd167458907;
      3:  r = 32'd85004756;
      4:  r = 32'd42667331;
      5:  r = 32'd21354465;
      6:  r = 32'd10679838;
      7:  r = 32'd5340245;
      8:  r = 32'd2670163;
      9:  r = 32'd1335087;
      10: r = 32'd667544;
      11: r = 32'd333772;
      12: r = 32'd166886;
      13: r = 32'd83443;
      14: r = 32'd41722;
      15: r = 32'd20861;
      16: r = 32'd10430;
      17: r = 32'd5215;
      18: r = 32'd2608;
      19: r = 32'd1304;
      20: r = 32'd652;
      21: r = 32'd326;
      22: r = 32'd163;
      23: r = 32'd81;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  // Arctangent brought to the angle scale, rounded half up.
  function automatic ang_t atan_entry(input int i);
    logic [32:0] t;
    t = {1'b0, atan_raw(i)} + (33'd1 << (30 - ANGLE_BITS));
    return Z_W'(t >> (31 - ANGLE_BITS));
  endfunction

  function automatic ang_t start_angle(input logic signed [15:0] a);
    if (SC >= 0) begin
      return ang_t'(a) <<< SC;
    end else begin
      return ang_t'(a >>> (-SC));
    end
  endfunction

endpackage
`default_nettype wire

// ----- sv/e2q_if.sv -----
// Valid/ready stream interfaces for the Euler-to-quaternion core.
`default_nettype none
interface e2q_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] yaw;
  logic [15:0] pitch;
  logic [15:0] roll;
  modport source (output valid, yaw, pitch, roll, input ready);
  modport sink   (input valid, yaw, pitch, roll, output ready);
endinterface

interface e2q_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] quat_x;
  logic [15:0] quat_y;
  logic [15:0] quat_z;
  logic [14:0] quat_w;
  modport source (output valid, quat_x, quat_y, quat_z, quat_w, input ready);
  modport sink   (input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface
`default_nettype wire

// ----- sv/e2q_cell.sv -----
// One CORDIC rotation cell for three angle lanes, registered.
`default_nettype none
module e2q_cell
  import e2q_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire logic [STAGE_W-1:0] stage_i,
  input  wire cell_t              cell_i,
  output cell_t                   cell_o
);

  // stage_i is tied per position in the chain, so both fold to constants
  ang_t atan_c;

  assign atan_c = atan_entry(int'(stage_i));

  function automatic lane_t rot(input lane_t l, input logic [STAGE_W-1:0] sh,
                                input ang_t at);
    lane_t r;
    xy_t   xs;
    xy_t   ys;
    xs = l.x >>> sh;
    ys = l.y >>> sh;
    if (!l.z[Z_W-1]) begin
      r.x = l.x - ys;
      r.y = l.y + xs;
      r.z = l.z - at;
    end else begin
      r.x = l.x + ys;
      r.y = l.y - xs;
      r.z = l.z + at;
    end
    return r;
  endfunction

  cell_t cell_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q.yaw   <= rot(cell_i.yaw, stage_i, atan_c);
      cell_q.pitch <= rot(cell_i.pitch, stage_i, atan_c);
      cell_q.roll  <= rot(cell_i.roll, stage_i, atan_c);
    end
  end

  assign cell_o = cell_q;

endmodule
`default_nettype wire

// ----- sv/e2q_combine.sv -----
// Quaternion product, sign fix, rounding and saturation, pipelined.
`default_nettype none
module e2q_combine
  import e2q_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         en_i,
  input  wire cell_t        cell_i,
  output logic [15:0]       quat_x_o,
  output logic [15:0]       quat_y_o,
  output logic [15:0]       quat_z_o,
  output logic [14:0]       quat_w_o
);

  localparam int P_W = 2 * XY_W;
  typedef logic signed [P_W-1:0] prod_t;

  // stage A: yaw*pitch products
  prod_t pw_m_q, px_m_q, py_m_q, pz_m_q;
  xy_t   cy_a_q, sy_a_q;
  // stage B: rounded to Q30
  xy_t   pw_q, px_q, py_q, pz_q, cy_b_q, sy_b_q;
  // stage C: eight products
  prod_t m_q [8];
  // stage D: sums with sign fix
  prod_t w_q, x_q, y_q, z_q;

  function automatic xy_t rnd30(input prod_t v);
    prod_t t;
    t = (v + (prod_t'(1) <<< 29)) >>> 30;
    return t[XY_W-1:0];
  endfunction

  function automatic logic signed [15:0] q14(input prod_t v, input logic w_lane);
    prod_t t;
    t = (v + (prod_t'(1) <<< 45)) >>> 46;
    if (t > prod_t'(16384)) t = prod_t'(16384);
    if (w_lane) begin
      if (t < prod_t'(0)) t = '0;
    end else if (t < -prod_t'(16384)) begin
      t = -prod_t'(16384);
    end
    return t[15:0];
  endfunction

  prod_t ws, xs, ys, zs;
  logic signed [15:0] qw;

  always_comb begin
    ws = m_q[0] - m_q[1];
    xs = m_q[2] - m_q[3];
    ys = m_q[4] + m_q[5];
    zs = m_q[6] + m_q[7];
    qw = q14(w_q, 1'b1);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pw_m_q <= prod_t'(cell_i.yaw.x) * prod_t'(cell_i.pitch.x);
      px_m_q <= prod_t'(cell_i.yaw.x) * prod_t'(cell_i.pitch.y);
      py_m_q <= prod_t'(cell_i.yaw.y) * prod_t'(cell_i.pitch.y);
      pz_m_q <= prod_t'(cell_i.yaw.y) * prod_t'(cell_i.pitch.x);
      cy_a_q <= cell_i.roll.x;
      sy_a_q <= cell_i.roll.y;

      pw_q <= rnd30(pw_m_q);
      px_q <= rnd30(px_m_q);
      py_q <= rnd30(py_m_q);
      pz_q <= rnd30(pz_m_q);
      cy_b_q <= cy_a_q;
      sy_b_q <= sy_a_q;

      m_q[0] <= prod_t'(pw_q) * prod_t'(cy_b_q);
      m_q[1] <= prod_t'(py_q) * prod_t'(sy_b_q);
      m_q[2] <= prod_t'(px_q) * prod_t'(cy_b_q);
      m_q[3] <= prod_t'(pz_q) * prod_t'(sy_b_q);
      m_q[4] <= prod_t'(pw_q) * prod_t'(sy_b_q);
      m_q[5] <= prod_t'(py_q) * prod_t'(cy_b_q);
      m_q[6] <= prod_t'(pz_q) * prod_t'(cy_b_q);
      m_q[7] <= prod_t'(px_q) * prod_t'(sy_b_q);

      if (ws < 0) begin
        w_q <= -ws; x_q <= -xs; y_q <= -ys; z_q <= -zs;
      end else begin
        w_q <= ws; x_q <= xs; y_q <= ys; z_q <= zs;
      end

      quat_x_o <= q14(x_q, 1'b0);
      quat_y_o <= q14(y_q, 1'b0);
      quat_z_o <= q14(z_q, 1'b0);
      quat_w_o <= qw[14:0];
    end
  end

endmodule
`default_nettype wire

// ----- sv/euler_to_quaternion_core.sv -----
// Top level: Euler angles (Z-X-Y) to unit quaternion converter.
//
// Input channel in_if carries one beat of yaw, pitch and roll, each a
// signed fraction of a half turn. Output channel out_if carries one beat
// of quat_x/y/z (signed Q1.14) and quat_w (unsigned Q1.14, never negative).
// Every input beat yields exactly one output beat, in order.
//
// Datapath: a chain of NUM_STAGES CORDIC cells (one per rotation step,
// all three angles side by side), then five stages of product, rounding,
// second product, sign fix and saturation. Throughput is one beat per
// cycle while the receiver does not stall the output.
//
// The whole pipe advances only when its last stage is empty or its beat
// is taken, so a stalled receiver freezes the pipe and in_ready drops;
// nothing is lost. Reset clears the valid bits only.
`default_nettype none
module euler_to_quaternion_core
  import e2q_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  e2q_in_if.sink    in_if,
  e2q_out_if.source out_if
);

  localparam int DEPTH = NUM_STAGES + 5;

  logic [DEPTH-1:0] vld_q;
  logic             adv;
  cell_t            chain [NUM_STAGES+1];

  assign adv          = !vld_q[DEPTH-1] || out_if.ready;
  assign in_if.ready  = adv;
  assign out_if.valid = vld_q[DEPTH-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[DEPTH-2:0], in_if.valid};
    end
  end

  always_comb begin
    chain[0].yaw   = '{x: CORDIC_GAIN, y: '0, z: start_angle(in_if.yaw)};
    chain[0].pitch = '{x: CORDIC_GAIN, y: '0, z: start_angle(in_if.pitch)};
    chain[0].roll  = '{x: CORDIC_GAIN, y: '0, z: start_angle(in_if.roll)};
  end

  for (genvar g = 0; g < NUM_STAGES; g++) begin : g_cell
    e2q_cell u_cell (
      .clk_i   (clk_i),
      .en_i    (adv),
      .stage_i (STAGE_W'(g)),
      .cell_i  (chain[g]),
      .cell_o  (chain[g+1])
    );
  end

  e2q_combine u_comb (
    .clk_i    (clk_i),
    .en_i     (adv),
    .cell_i   (chain[NUM_STAGES]),
    .quat_x_o (out_if.quat_x),
    .quat_y_o (out_if.quat_y),
    .quat_z_o (out_if.quat_z),
    .quat_w_o (out_if.quat_w)
  );

endmodule
`default_nettype wire

// ----- sv/e2q_checker.sv -----
// Port-level assertions for the Euler-to-quaternion core, bound to the top.
`default_nettype none
module e2q_assert (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [15:0] quat_x_i,
  input wire logic [14:0] quat_w_i
);

  a_w_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> quat_w_i <= 15'd16384) else $error("w out of range");

  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i) else $error("ready low with empty output");

  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(quat_x_i))
    else $error("stalled beat changed");

  a_no_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("input taken while stalled");

endmodule

bind euler_to_quaternion_core e2q_assert u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_if.valid),
  .in_ready_i  (in_if.ready),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .quat_x_i    (out_if.quat_x),
  .quat_w_i    (out_if.quat_w)
);
`default_nettype wire
